[hdl/wor_pkg.sv]
// Shared types and constants for the weak observer registry.
// Used by wor_ctrl, wor_datapath and weak_observer_registry; no dependencies.
`default_nettype none
package wor_pkg;

  localparam int unsigned ENTRIES_DEF = 64;
  localparam int unsigned ADDR_W      = 64;
  localparam int unsigned KIND_W      = 2;
  localparam int unsigned OP_W        = 2;
  localparam int unsigned ST_W        = 3;
  localparam int unsigned LIVE_W      = 7;

  typedef enum logic [OP_W-1:0] {
    OP_REGISTER   = 2'd0,
    OP_DEREGISTER = 2'd1,
    OP_DYING      = 2'd2,
    OP_UNKNOWN    = 2'd3
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_REGISTERED = 3'd0,
    ST_NULL       = 3'd1,
    ST_FULL       = 3'd2,
    ST_REMOVED    = 3'd3,
    ST_NOTFOUND   = 3'd4,
    ST_NOTICE     = 3'd5,
    ST_NONE       = 3'd6
  } status_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic    load;
    logic    cmp;
    logic    push;
    logic    remove;
    logic    pop1;
    logic    pop2;
    logic    rot_step;
    logic    emit;
    logic    emit_notice;
    logic    emit_last;
    status_e emit_status;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    op_e  op;
    logic tgt_null;
    logic full;
    logic found;
    logic none_match;
    logic head_match;
    logic last_match;
    logic out_free;
    logic rot_done;
  } sts_t;

endpackage
`default_nettype wire

[hdl/wor_datapath.sv]
// Datapath of the weak observer registry: record cells, compare vectors,
// match counter, rotation counters and the result register. Uses wor_pkg.
`default_nettype none
module wor_datapath #(
  parameter int unsigned ENTRIES = wor_pkg::ENTRIES_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire wor_pkg::op_e               op_i,
  input  wire logic [wor_pkg::ADDR_W-1:0] target_i,
  input  wire logic [wor_pkg::KIND_W-1:0] kind_i,
  input  wire logic [wor_pkg::ADDR_W-1:0] owner_i,
  input  wire wor_pkg::cmd_t              cmd_i,
  output wor_pkg::sts_t                   sts_o,
  input  wire logic                       out_ready_i,
  output logic                            out_valid_o,
  output wor_pkg::status_e                out_status_o,
  output logic [wor_pkg::KIND_W-1:0]      out_kind_o,
  output logic [wor_pkg::ADDR_W-1:0]      out_owner_o,
  output logic [wor_pkg::ADDR_W-1:0]      out_target_o,
  output logic [wor_pkg::LIVE_W-1:0]      out_live_o,
  output logic                            out_last_o
);

  localparam int unsigned CW = $clog2(ENTRIES + 1);
  localparam int unsigned G  = (ENTRIES + 7) / 8;

  // Latched item
  wor_pkg::op_e               op_q;
  logic [wor_pkg::ADDR_W-1:0] tgt_q, own_q;
  logic [wor_pkg::KIND_W-1:0] kind_q;

  // Record cells, newest at cell 0
  logic [wor_pkg::ADDR_W-1:0] cell_tgt_q  [ENTRIES];
  logic [wor_pkg::KIND_W-1:0] cell_kind_q [ENTRIES];
  logic [wor_pkg::ADDR_W-1:0] cell_own_q  [ENTRIES];
  logic [CW-1:0]              cnt_q;

  logic [ENTRIES-1:0] tm_d, fm_d, tm_q, fm_q, rm_en;
  logic [G*8-1:0]     tm_pad;
  logic [3:0]         grp_q [G];
  logic [CW-1:0]      grp_sum;
  logic [CW-1:0]      rot_q, rem_q, fin_q;
  logic               hm, out_free;

  // Output register
  logic                       ov_q, olast_q;
  wor_pkg::status_e           ost_q;
  logic [wor_pkg::KIND_W-1:0] okind_q;
  logic [wor_pkg::ADDR_W-1:0] oown_q, otgt_q;
  logic [wor_pkg::LIVE_W-1:0] olive_q;

  // Compare every held cell against the latched item
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      tm_d[i] = (CW'(i) < cnt_q) && (cell_tgt_q[i] == tgt_q);
      fm_d[i] = tm_d[i] && (cell_kind_q[i] == kind_q) && (cell_own_q[i] == own_q);
    end
  end

  // Shift enable for removal: at and above the newest match
  for (genvar g = 0; g < ENTRIES; g++) begin : g_rm
    assign rm_en[g] = |fm_q[g:0];
  end

  assign tm_pad   = (G * 8)'(tm_q);
  assign hm       = (cell_tgt_q[0] == tgt_q);
  assign out_free = !ov_q || out_ready_i;

  // Sum the group counts
  always_comb begin
    grp_sum = '0;
    for (int g = 0; g < G; g++) begin
      grp_sum = grp_sum + CW'(grp_q[g]);
    end
  end

  // Latch the item, the compare vectors and the group counts
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= op_i;
      tgt_q  <= target_i;
      kind_q <= kind_i;
      own_q  <= owner_i;
    end
    if (cmd_i.cmp) begin
      tm_q <= tm_d;
      fm_q <= fm_d;
    end
    if (cmd_i.pop1) begin
      for (int g = 0; g < G; g++) begin
        grp_q[g] <= 4'($countones(tm_pad[g*8 +: 8]));
      end
    end
  end

  // Move cells: push at the head, close a gap, or rotate one step
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      cell_tgt_q[0]  <= tgt_q;
      cell_kind_q[0] <= kind_q;
      cell_own_q[0]  <= own_q;
      for (int i = 1; i < ENTRIES; i++) begin
        cell_tgt_q[i]  <= cell_tgt_q[i-1];
        cell_kind_q[i] <= cell_kind_q[i-1];
        cell_own_q[i]  <= cell_own_q[i-1];
      end
    end else if (cmd_i.remove) begin
      for (int i = 0; i < ENTRIES - 1; i++) begin
        if (rm_en[i]) begin
          cell_tgt_q[i]  <= cell_tgt_q[i+1];
          cell_kind_q[i] <= cell_kind_q[i+1];
          cell_own_q[i]  <= cell_own_q[i+1];
        end
      end
    end else if (cmd_i.rot_step) begin
      // keep a non-matching head by moving it to the tail
      for (int i = 0; i < ENTRIES - 1; i++) begin
        if (!hm && (CW'(i) + CW'(1) == cnt_q)) begin
          cell_tgt_q[i]  <= cell_tgt_q[0];
          cell_kind_q[i] <= cell_kind_q[0];
          cell_own_q[i]  <= cell_own_q[0];
        end else begin
          cell_tgt_q[i]  <= cell_tgt_q[i+1];
          cell_kind_q[i] <= cell_kind_q[i+1];
          cell_own_q[i]  <= cell_own_q[i+1];
        end
      end
      if (!hm && (cnt_q == CW'(ENTRIES))) begin
        cell_tgt_q[ENTRIES-1]  <= cell_tgt_q[0];
        cell_kind_q[ENTRIES-1] <= cell_kind_q[0];
        cell_own_q[ENTRIES-1]  <= cell_own_q[0];
      end
    end
  end

  // Record count and rotation counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rot_q <= '0;
      rem_q <= '0;
      fin_q <= '0;
    end else begin
      if (cmd_i.push) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (cmd_i.remove || (cmd_i.rot_step && hm)) begin
        cnt_q <= cnt_q - CW'(1);
      end
      if (cmd_i.pop2) begin
        rot_q <= cnt_q;
        rem_q <= grp_sum;
        fin_q <= cnt_q - grp_sum;
      end else if (cmd_i.rot_step) begin
        rot_q <= rot_q - CW'(1);
        if (hm) begin
          rem_q <= rem_q - CW'(1);
        end
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (cmd_i.emit) begin
      ov_q <= 1'b1;
    end else if (out_ready_i) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      ost_q   <= cmd_i.emit_status;
      olast_q <= cmd_i.emit_last;
      okind_q <= cmd_i.emit_notice ? cell_kind_q[0] : '0;
      oown_q  <= cmd_i.emit_notice ? cell_own_q[0] : '0;
      otgt_q  <= cmd_i.emit_notice ? tgt_q : '0;
      olive_q <= wor_pkg::LIVE_W'(cmd_i.emit_notice ? fin_q : cnt_q);
    end
  end

  assign out_valid_o  = ov_q;
  assign out_status_o = ost_q;
  assign out_kind_o   = okind_q;
  assign out_owner_o  = oown_q;
  assign out_target_o = otgt_q;
  assign out_live_o   = olive_q;
  assign out_last_o   = olast_q;

  always_comb begin
    sts_o            = '0;
    sts_o.op         = op_q;
    sts_o.tgt_null   = (tgt_q == '0);
    sts_o.full       = (cnt_q == CW'(ENTRIES));
    sts_o.found      = |fm_q;
    sts_o.none_match = (rem_q == '0);
    sts_o.head_match = hm;
    sts_o.last_match = (rem_q == CW'(1));
    sts_o.out_free   = out_free;
    sts_o.rot_done   = (rot_q == '0);
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(ENTRIES)) else $error("record count beyond table size");
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> out_free) else $error("result written over a pending one");
  a_notice_hm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit && cmd_i.emit_notice) |-> (cmd_i.rot_step && hm))
    else $error("notice without a matching head cell");
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push |-> (cnt_q < CW'(ENTRIES))) else $error("push into a full table");

endmodule
`default_nettype wire

[hdl/wor_ctrl.sv]
// Controller state machine of the weak observer registry.
// Drives wor_datapath commands from its status; uses wor_pkg.
`default_nettype none
module wor_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire wor_pkg::sts_t sts_i,
  output wor_pkg::cmd_t      cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_CMP, S_ACT, S_CNT1, S_CNT2, S_CHK, S_RESP, S_ROT
  } state_e;

  state_e           state_q;
  wor_pkg::status_e resp_q;

  // Decode commands from the state
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      S_CMP:  cmd_o.cmp = 1'b1;
      S_ACT: begin
        if (sts_i.op == wor_pkg::OP_REGISTER) begin
          cmd_o.push = !sts_i.tgt_null && !sts_i.full;
        end else if (sts_i.op == wor_pkg::OP_DEREGISTER) begin
          cmd_o.remove = !sts_i.tgt_null && sts_i.found;
        end
      end
      S_CNT1: cmd_o.pop1 = 1'b1;
      S_CNT2: cmd_o.pop2 = 1'b1;
      S_RESP: begin
        cmd_o.emit        = sts_i.out_free;
        cmd_o.emit_last   = 1'b1;
        cmd_o.emit_status = resp_q;
      end
      S_ROT: begin
        if (!sts_i.rot_done) begin
          // stall a matching head until the result register frees
          cmd_o.rot_step    = !sts_i.head_match || sts_i.out_free;
          cmd_o.emit        = sts_i.head_match && sts_i.out_free;
          cmd_o.emit_notice = cmd_o.emit;
          cmd_o.emit_last   = sts_i.last_match;
          cmd_o.emit_status = wor_pkg::ST_NOTICE;
        end
      end
      default: ;
    endcase
  end

  // Advance state and hold the pending response code
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      resp_q  <= wor_pkg::ST_NONE;
    end else begin
      case (state_q)
        S_IDLE: if (in_valid_i) state_q <= S_CMP;
        S_CMP:  state_q <= S_ACT;
        S_ACT: begin
          state_q <= S_RESP;
          case (sts_i.op)
            wor_pkg::OP_REGISTER: begin
              if (sts_i.tgt_null)  resp_q <= wor_pkg::ST_NULL;
              else if (sts_i.full) resp_q <= wor_pkg::ST_FULL;
              else                 resp_q <= wor_pkg::ST_REGISTERED;
            end
            wor_pkg::OP_DEREGISTER: begin
              if (sts_i.tgt_null)   resp_q <= wor_pkg::ST_NULL;
              else if (sts_i.found) resp_q <= wor_pkg::ST_REMOVED;
              else                  resp_q <= wor_pkg::ST_NOTFOUND;
            end
            wor_pkg::OP_DYING: state_q <= S_CNT1;
            default: resp_q <= wor_pkg::ST_NONE;
          endcase
        end
        S_CNT1: state_q <= S_CNT2;
        S_CNT2: state_q <= S_CHK;
        S_CHK: begin
          if (sts_i.none_match) begin
            resp_q  <= wor_pkg::ST_NONE;
            state_q <= S_RESP;
          end else begin
            state_q <= S_ROT;
          end
        end
        S_RESP: if (sts_i.out_free) state_q <= S_IDLE;
        S_ROT:  if (sts_i.rot_done) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (state_q == S_IDLE)) else $error("ready outside idle");
  a_one_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.push, cmd_o.remove, cmd_o.rot_step}))
    else $error("conflicting cell moves");
  a_accept_cmp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_CMP))
    else $error("accepted item not compared");

endmodule
`default_nettype wire

[hdl/weak_observer_registry.sv]
// Top level of the weak observer registry: stream ports and packing.
// Instantiates wor_ctrl and wor_datapath; uses wor_pkg.
`default_nettype none
// Holds up to ENTRIES observer records newest first. Register, deregister
// and unknown operations give one result each. A target-dying operation
// gives one notice per matching record, or a single result when none
// does: all cells are compared in parallel, the matches are counted in two
// registered stages, then the table rotates once through its head cell, one
// record per cycle, emitting a notice for each matching record and closing
// up behind it. The next item is accepted only when the previous one is
// finished; a stalled result register stalls the rotation.
module weak_observer_registry #(
  parameter int unsigned ENTRIES = wor_pkg::ENTRIES_DEF
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // [63:0] target_addr, [65:64] observer_kind, [129:66] owner_addr, zero pad
  input  wire logic [135:0] s_axis_tdata,
  // [1:0] operation
  input  wire logic [1:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // [1:0] notice_kind, [65:2] notice_owner, [129:66] notice_target,
  // [136:130] live_records, zero pad
  output logic [143:0]      m_axis_tdata,
  // [2:0] status
  output logic [2:0]        m_axis_tuser,
  output logic              m_axis_tlast
);

  wor_pkg::cmd_t                cmd;
  wor_pkg::sts_t                sts;
  wor_pkg::status_e             out_status;
  logic [wor_pkg::KIND_W-1:0]   out_kind;
  logic [wor_pkg::ADDR_W-1:0]   out_owner, out_target;
  logic [wor_pkg::LIVE_W-1:0]   out_live;

  wor_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  wor_datapath #(.ENTRIES(ENTRIES)) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .op_i         (wor_pkg::op_e'(s_axis_tuser)),
    .target_i     (s_axis_tdata[63:0]),
    .kind_i       (s_axis_tdata[65:64]),
    .owner_i      (s_axis_tdata[129:66]),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_status_o (out_status),
    .out_kind_o   (out_kind),
    .out_owner_o  (out_owner),
    .out_target_o (out_target),
    .out_live_o   (out_live),
    .out_last_o   (m_axis_tlast)
  );

  // Pack the result transaction
  assign m_axis_tdata = {7'd0, out_live, out_target, out_owner, out_kind};
  assign m_axis_tuser = out_status;

endmodule
`default_nettype wire
